// ===== hdl/ksn_pkg.sv =====
// Package for the 3-5-7 smooth number generator.
// Holds the table size, field widths and the sequencer state type.
// No dependencies.
package ksn_pkg;

  localparam int MAX_K   = 1024;
  localparam int ADDR_W  = $clog2(MAX_K + 1);
  localparam int INDEX_W = 16;
  localparam int VALUE_W = 63;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [VALUE_W-1:0] value_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FA,
    ST_FB,
    ST_FC,
    ST_RDK,
    ST_FIN
  } state_t;

endpackage

// ===== hdl/ksn_in_if.sv =====
// Request channel of the smooth number generator: valid, ready and the index.
// Depends on ksn_pkg.
interface ksn_in_if import ksn_pkg::*; ();
  logic   valid;
  logic   ready;
  index_t target_index;

  modport source (output valid, output target_index, input ready);
  modport sink   (input valid, input target_index, output ready);
endinterface

// ===== hdl/ksn_out_if.sv =====
// Result channel of the smooth number generator: valid, ready, value and status.
// Depends on ksn_pkg.
interface ksn_out_if import ksn_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t smooth_value;
  logic   status;

  modport source (output valid, output smooth_value, output status, input ready);
  modport sink   (input valid, input smooth_value, input status, output ready);
endinterface

// ===== hdl/kth_357_smooth_number.sv =====
// Returns the k-th smallest number whose only prime factors are 3, 5 and 7 (1 is first).
// A two-read-port table memory holds the sequence between requests; a request extends
// it up to index k by the three-pointer merge; each new entry passes ST_FA (read the
// pointer 3 and 5 entries), ST_FB (read the pointer 7 entry) and ST_FC (compare and
// write back). It then reads entry k through ST_RDK and ST_FIN. A request that needs
// no new entry goes from ST_IDLE straight to ST_RDK. Index 0 or above MAX_K answers
// status 1 and value 0. After reset, ST_INIT seeds entry 1 before the first transfer.
// Depends on ksn_pkg, ksn_in_if and ksn_out_if.
module kth_357_smooth_number import ksn_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ksn_in_if.sink       req,
  ksn_out_if.source    rsp
);

  value_t mem [0:MAX_K];

  state_t state, state_next;
  addr_t  p3, p5, p7, fill;
  index_t k;
  logic   err;
  value_t v3, v5;
  value_t rd_a, rd_b;
  addr_t  ra, rb;
  logic   we;

  logic   out_valid;
  value_t out_value;
  logic   out_status;

  value_t c3, c5, c7, m;
  addr_t  fill_inc;
  logic   bad;
  logic   out_free;
  logic   load;

  assign c3       = {v3[VALUE_W-2:0], 1'b0} + v3;
  assign c5       = {v5[VALUE_W-3:0], 2'b0} + v5;
  assign c7       = {rd_a[VALUE_W-4:0], 3'b0} - rd_a;
  assign m        = (c3 < c5) ? ((c3 < c7) ? c3 : c7) : ((c5 < c7) ? c5 : c7);
  assign fill_inc = fill + addr_t'(1);
  assign bad      = (req.target_index == '0) || (req.target_index > index_t'(MAX_K));
  assign out_free = !out_valid || rsp.ready;
  assign load     = (state == ST_FIN) && out_free;

  assign req.ready        = (state == ST_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.smooth_value = out_value;
  assign rsp.status       = out_status;

  always_comb begin
    state_next = state;
    ra         = p3;
    rb         = p5;
    we         = 1'b0;
    case (state)
      ST_INIT: begin
        we         = 1'b1;
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req.valid) begin
          if (bad) begin
            state_next = ST_FIN;
          end else if (index_t'(fill) >= req.target_index) begin
            state_next = ST_RDK;
          end else begin
            state_next = ST_FA;
          end
        end
      end
      ST_FA: begin
        state_next = ST_FB;
      end
      ST_FB: begin
        ra         = p7;
        state_next = ST_FC;
      end
      ST_FC: begin
        we         = 1'b1;
        state_next = (index_t'(fill_inc) >= k) ? ST_RDK : ST_FA;
      end
      ST_RDK: begin
        ra         = k[ADDR_W-1:0];
        state_next = ST_FIN;
      end
      ST_FIN: begin
        ra = k[ADDR_W-1:0];
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      if (state == ST_INIT) begin
        mem[1] <= value_t'(1);
      end else begin
        mem[fill_inc] <= m;
      end
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3   <= addr_t'(1);
      p5   <= addr_t'(1);
      p7   <= addr_t'(1);
      fill <= addr_t'(1);
    end else if (state == ST_FC) begin
      fill <= fill_inc;
      if (c3 == m) p3 <= p3 + addr_t'(1);
      if (c5 == m) p5 <= p5 + addr_t'(1);
      if (c7 == m) p7 <= p7 + addr_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      k   <= req.target_index;
      err <= bad;
    end
    if (state == ST_FB) begin
      v3 <= rd_a;
      v5 <= rd_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value  <= err ? '0 : rd_a;
      out_status <= err;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    (fill >= addr_t'(1)) && (fill <= addr_t'(MAX_K)))
    else $error("fill position out of range");

  a_ptr_behind_fill: assert property (@(posedge clk) disable iff (rst)
    (p3 <= fill) && (p5 <= fill) && (p7 <= fill))
    else $error("pointer ahead of fill position");

  a_fill_only_in_merge: assert property (@(posedge clk) disable iff (rst)
    (state != ST_FC) |=> $stable(fill))
    else $error("fill position moved outside merge step");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while busy");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    load && err |=> out_valid && out_status && (out_value == '0))
    else $error("error result carries a value");
`endif

endmodule
